FILE: src/isotropic_diffusion_stencil_core_assert.svh
// Assertion macros shared by the diffusion stencil RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ISOTROPIC_DIFFUSION_STENCIL_CORE_ASSERT_SVH
`define ISOTROPIC_DIFFUSION_STENCIL_CORE_ASSERT_SVH

// The condition must never hold outside reset.
`define IDS_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define IDS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define IDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

FILE: src/ids_pkg.sv
// Shared types and constants for the isotropic diffusion stencil core.
// No dependencies; every RTL module imports this package.
package ids_pkg;

    localparam int PIX_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 13;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;
    localparam int LAP_W      = 19;
    localparam int PROD_W     = 36;
    localparam int GAIN_SHIFT = 16;
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int RESET_GAIN = 13107;
    localparam int RESET_DIM  = 1024;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t up;
        pixel_t down;
        pixel_t left;
        pixel_t center;
        pixel_t right;
        logic   border;
        logic   last;
    } job_t;

    typedef struct packed {
        pixel_t pixel;
        logic   last;
        logic   clipped;
    } result_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

FILE: src/isotropic_diffusion_stencil_core.sv
// Top level of the isotropic diffusion stencil: one explicit five-point update per pixel.
// A result passes the front registers, job queue, back-end lap and product registers
// and result queue. Unless full or a missing pop stalls it, one item is accepted and one
// result delivered per cycle; the line stores have one read and one write port each,
// used once per item. Results follow the input stream by frame width plus one items.
// Reset is asynchronous: counters, window and queues clear; line stores keep contents.
module isotropic_diffusion_stencil_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ids_pkg::IDX_W-1:0] cfg_index,
    input  logic [ids_pkg::CFG_W-1:0] cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      cmd,
    input  logic [ids_pkg::PIX_W-1:0] pixel_in,
    input  logic                      start_of_frame,
    output logic                      empty,
    input  logic                      pop,
    output logic [ids_pkg::PIX_W-1:0] pixel_out,
    output logic                      last,
    output logic                      clipped
);
    import ids_pkg::*;

    `include "isotropic_diffusion_stencil_core_assert.svh"

    logic [GAIN_W-1:0] gain_reg;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;

    queue_status_t     job_status;
    queue_status_t     res_status;
    job_t              job_in;
    job_t              job_out;
    logic              job_push;
    logic              job_pop;
    result_t           res_in;
    result_t           res_out;
    logic              res_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_W'(RESET_GAIN);
            width_reg  <= FW_W'(RESET_DIM);
            height_reg <= FH_W'(RESET_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:    ;
            endcase
        end
    end

    ids_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .cmd            (cmd),
        .pixel_in       (pixel_in),
        .start_of_frame (start_of_frame),
        .full           (full),
        .frame_width    (width_reg),
        .frame_height   (height_reg),
        .job_status     (job_status),
        .job_push       (job_push),
        .job            (job_in)
    );

    ids_queue #(
        .WIDTH($bits(job_t))
    ) u_job_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .status    (job_status)
    );

    ids_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_status (job_status),
        .job        (job_out),
        .job_pop    (job_pop),
        .gain       (gain_reg),
        .res_status (res_status),
        .res_push   (res_push),
        .result     (res_in)
    );

    ids_queue #(
        .WIDTH($bits(result_t))
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .pop       (pop),
        .pop_data  (res_out),
        .status    (res_status)
    );

    assign empty     = res_status.empty;
    assign pixel_out = res_out.pixel;
    assign last      = res_out.last;
    assign clipped   = res_out.clipped;

    `IDS_ASSERT_NEVER(a_job_queue_no_overflow, job_push && job_status.full)
    `IDS_ASSERT_NEVER(a_res_queue_no_overflow, res_push && res_status.full)
    `IDS_ASSERT_IMPLY(a_clip_is_saturated, !empty && clipped, pixel_out == '0 || pixel_out == '1)
    `IDS_ASSERT_NEXT(a_pop_feeds_back, job_pop, u_back.v1_reg)

endmodule

FILE: src/ids_queue.sv
// Small register-based FIFO used between the front, the back and the result port.
// Depends on ids_pkg for the depth and the status struct.
module ids_queue #(
    parameter int WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output ids_pkg::queue_status_t status
);
    import ids_pkg::*;

    logic [WIDTH-1:0]  data_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/ids_front.sv
// Front end: accepts items, tracks frame position, runs the line stores and window.
// Depends on ids_pkg; emits stencil jobs into the job queue.
module ids_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     cmd,
    input  ids_pkg::pixel_t          pixel_in,
    input  logic                     start_of_frame,
    output logic                     full,
    input  logic [ids_pkg::FW_W-1:0] frame_width,
    input  logic [ids_pkg::FH_W-1:0] frame_height,
    input  ids_pkg::queue_status_t   job_status,
    output logic                     job_push,
    output ids_pkg::job_t            job
);
    import ids_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    pixel_t prior_row_store  [MAX_WIDTH];
    pixel_t center_row_store [MAX_WIDTH];

    logic [WW-1:0]    col_reg;
    logic [WW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [WW-1:0]    ocol_reg;
    logic [WW-1:0]    ocol_next;
    logic [ROW_W-1:0] orow_reg;
    logic [ROW_W-1:0] orow_next;
    logic [WW-1:0]    act_w_reg;
    logic [WW-1:0]    act_w_next;
    logic [ROW_W-1:0] act_h_reg;
    logic [ROW_W-1:0] act_h_next;

    logic [WW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [WW-1:0]    ocol_cur;
    logic [ROW_W-1:0] orow_cur;
    logic [WW-1:0]    new_w;
    logic [ROW_W-1:0] new_h;
    logic [WW-1:0]    col_inc;
    logic [WW-1:0]    ocol_inc;
    logic             accept;
    logic             latch;
    logic             pix_path;
    logic             adv;
    logic             emit;
    logic             border;
    logic             last_pos;
    logic [AW-1:0]    addr;
    pixel_t           x_in;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_border_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    pixel_t           s1_x_reg;
    logic [AW-1:0]    s1_addr_reg;
    pixel_t           fwd_a_reg;
    pixel_t           fwd_b_reg;
    pixel_t           prior_q_reg;
    pixel_t           center_q_reg;
    pixel_t           s1_a;
    pixel_t           s1_b;

    pixel_t           win0_reg;
    pixel_t           win1_reg;
    pixel_t           win2_reg;
    pixel_t           up_hold_reg;
    pixel_t           down_hold_reg;

    assign full   = (job_status.count + QCNT_W'(s1_valid_reg && s1_emit_reg))
                    >= QCNT_W'(QUEUE_DEPTH);
    assign accept = push && !full;

    always_comb
    begin
        int unsigned fw_i;
        int unsigned fh_i;
        fw_i = 32'(frame_width);
        fh_i = 32'(frame_height);
        if (fw_i < MIN_DIM)
        begin
            new_w = WW'(MIN_DIM);
        end
        else if (fw_i > MAX_WIDTH)
        begin
            new_w = WW'(MAX_WIDTH);
        end
        else
        begin
            new_w = WW'(fw_i);
        end
        if (fh_i < MIN_DIM)
        begin
            new_h = ROW_W'(MIN_DIM);
        end
        else if (fh_i > MAX_HEIGHT)
        begin
            new_h = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            new_h = ROW_W'(fh_i);
        end
    end

    always_comb
    begin
        latch = !cmd && (start_of_frame || (row_reg == '0 && col_reg == '0
                && orow_reg == '0 && ocol_reg == '0));
        act_w_next = latch ? new_w : act_w_reg;
        act_h_next = latch ? new_h : act_h_reg;
        col_cur    = latch ? '0 : col_reg;
        row_cur    = latch ? '0 : row_reg;
        ocol_cur   = latch ? '0 : ocol_reg;
        orow_cur   = latch ? '0 : orow_reg;

        pix_path = !cmd && (row_cur < act_h_next);
        adv      = pix_path || (row_cur >= act_h_next && orow_cur < act_h_next);
        if (pix_path)
        begin
            emit = (row_cur >= ROW_W'(2)) || (row_cur == ROW_W'(1) && col_cur != '0);
        end
        else
        begin
            emit = adv;
        end
        x_in = pix_path ? pixel_in : '0;
        addr = col_cur[AW-1:0];

        col_inc  = col_cur + 1'b1;
        col_next = col_cur;
        row_next = row_cur;
        if (adv)
        begin
            if (col_inc >= act_w_next)
            begin
                col_next = '0;
                row_next = row_cur + 1'b1;
            end
            else
            begin
                col_next = col_inc;
            end
        end

        border   = (orow_cur == '0) || (orow_cur == act_h_next - 1'b1)
                   || (ocol_cur == '0) || (ocol_cur == act_w_next - 1'b1);
        last_pos = (orow_cur == act_h_next - 1'b1) && (ocol_cur == act_w_next - 1'b1);
        ocol_inc  = ocol_cur + 1'b1;
        ocol_next = ocol_cur;
        orow_next = orow_cur;
        if (emit)
        begin
            if (ocol_inc >= act_w_next)
            begin
                ocol_next = '0;
                orow_next = orow_cur + 1'b1;
            end
            else
            begin
                ocol_next = ocol_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            act_w_reg    <= WW'(MAX_WIDTH < RESET_DIM ? MAX_WIDTH : RESET_DIM);
            act_h_reg    <= ROW_W'(RESET_DIM);
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && adv;
            s1_emit_reg  <= accept && adv && emit;
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                ocol_reg  <= ocol_next;
                orow_reg  <= orow_next;
                act_w_reg <= act_w_next;
                act_h_reg <= act_h_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && adv)
        begin
            s1_border_reg <= border;
            s1_last_reg   <= last_pos;
            s1_x_reg      <= x_in;
            s1_addr_reg   <= addr;
            s1_fwd_reg    <= s1_valid_reg && (s1_addr_reg == addr);
            fwd_a_reg     <= s1_x_reg;
            fwd_b_reg     <= s1_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && adv)
        begin
            prior_q_reg <= prior_row_store[addr];
        end
        if (s1_valid_reg)
        begin
            prior_row_store[s1_addr_reg] <= s1_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && adv)
        begin
            center_q_reg <= center_row_store[addr];
        end
        if (s1_valid_reg)
        begin
            center_row_store[s1_addr_reg] <= s1_x_reg;
        end
    end

    assign s1_a = s1_fwd_reg ? fwd_a_reg : center_q_reg;
    assign s1_b = s1_fwd_reg ? fwd_b_reg : prior_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg      <= '0;
            win1_reg      <= '0;
            win2_reg      <= '0;
            up_hold_reg   <= '0;
            down_hold_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win0_reg      <= win1_reg;
            win1_reg      <= win2_reg;
            win2_reg      <= s1_a;
            up_hold_reg   <= s1_b;
            down_hold_reg <= s1_x_reg;
        end
    end

    assign job_push    = s1_valid_reg && s1_emit_reg;
    assign job.up      = up_hold_reg;
    assign job.down    = down_hold_reg;
    assign job.left    = win1_reg;
    assign job.center  = win2_reg;
    assign job.right   = s1_a;
    assign job.border  = s1_border_reg;
    assign job.last    = s1_last_reg;

endmodule

FILE: src/ids_back.sv
// Back end: saturating diffusion update per interior job; border jobs pass the center.
// Depends on ids_pkg; pops the job queue and pushes the result queue.
module ids_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ids_pkg::queue_status_t     job_status,
    input  ids_pkg::job_t              job,
    output logic                       job_pop,
    input  logic [ids_pkg::GAIN_W-1:0] gain,
    input  ids_pkg::queue_status_t     res_status,
    output logic                       res_push,
    output ids_pkg::result_t           result
);
    import ids_pkg::*;

    localparam int SUM_W = PIX_W + 2;
    localparam int SHF_W = PROD_W - GAIN_SHIFT;
    localparam int F_W   = SHF_W + 1;

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [LAP_W-1:0]  lap_reg;
    pixel_t                   c1_center_reg;
    logic                     c1_border_reg;
    logic                     c1_last_reg;
    logic [GAIN_W-1:0]        c1_gain_reg;
    logic signed [PROD_W-1:0] prod_reg;
    pixel_t                   c2_center_reg;
    logic                     c2_border_reg;
    logic                     c2_last_reg;

    logic [SUM_W-1:0]         sum4;
    logic signed [LAP_W-1:0]  lap;
    logic signed [PROD_W-1:0] prod;
    logic signed [F_W-1:0]    f;

    assign job_pop = !job_status.empty
                     && ((res_status.count + QCNT_W'(v1_reg) + QCNT_W'(v2_reg))
                         < QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        sum4 = SUM_W'(job.up) + SUM_W'(job.down) + SUM_W'(job.left) + SUM_W'(job.right);
        lap  = $signed({1'b0, sum4}) - $signed({1'b0, job.center, 2'b00});
        prod = PROD_W'($signed({1'b0, c1_gain_reg})) * PROD_W'(lap_reg);
        f    = $signed(F_W'({1'b0, c2_center_reg}))
               + $signed({prod_reg[PROD_W-1], prod_reg[PROD_W-1:GAIN_SHIFT]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= job_pop;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            lap_reg       <= lap;
            c1_center_reg <= job.center;
            c1_border_reg <= job.border;
            c1_last_reg   <= job.last;
            c1_gain_reg   <= gain;
        end
        if (v1_reg)
        begin
            prod_reg      <= prod;
            c2_center_reg <= c1_center_reg;
            c2_border_reg <= c1_border_reg;
            c2_last_reg   <= c1_last_reg;
        end
    end

    always_comb
    begin
        res_push     = v2_reg;
        result.last  = c2_last_reg;
        if (c2_border_reg)
        begin
            result.pixel   = c2_center_reg;
            result.clipped = 1'b0;
        end
        else if (f < 0)
        begin
            result.pixel   = '0;
            result.clipped = 1'b1;
        end
        else if (f > $signed(F_W'({1'b0, {PIX_W{1'b1}}})))
        begin
            result.pixel   = '1;
            result.clipped = 1'b1;
        end
        else
        begin
            result.pixel   = f[PIX_W-1:0];
            result.clipped = 1'b0;
        end
    end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the isotropic diffusion stencil core.
// Depends on ids_pkg and isotropic_diffusion_stencil_core; an internal predictor
// works out every expected result beat, and random gaps and stalls hit both handshakes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ids_pkg::*;

    localparam int TB_MAX_WIDTH  = 1024;
    localparam int TOTAL_BEATS   = 550;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic {ITEM_PIXEL = 1'b0, ITEM_DRAIN = 1'b1} item_kind_t;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
    endfunction

    class diffusion_scoreboard;
        pixel_t      prior_row [TB_MAX_WIDTH];
        pixel_t      center_row [TB_MAX_WIDTH];
        pixel_t      window [3];
        pixel_t      up_hold;
        pixel_t      down_hold;
        int unsigned col;
        int unsigned row;
        int unsigned emitted;
        int unsigned gain;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned frame_w;
        int unsigned frame_h;
        result_t     pending_results [$];
        int unsigned mismatches;

        function new();
            foreach (prior_row[i])
            begin
                prior_row[i] = '0;
                center_row[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            up_hold = '0;
            down_hold = '0;
            col = 0;
            row = 0;
            emitted = 0;
            gain = RESET_GAIN;
            width_reg = RESET_DIM;
            height_reg = RESET_DIM;
            frame_w = clamp_dim(width_reg, TB_MAX_WIDTH);
            frame_h = clamp_dim(height_reg, MAX_HEIGHT);
            mismatches = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, int unsigned value);
            case (idx)
                REG_GAIN:   gain = value & ((1 << GAIN_W) - 1);
                REG_WIDTH:  width_reg = value & ((1 << FW_W) - 1);
                REG_HEIGHT: height_reg = value & ((1 << FH_W) - 1);
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void shift_stencil(pixel_t x, bit may_emit);
            int unsigned c;
            int unsigned qr;
            int unsigned qc;
            pixel_t      above;
            pixel_t      above2;
            pixel_t      up;
            pixel_t      down;
            longint      lap;
            longint      acc;
            result_t     r;
            c = (col >= TB_MAX_WIDTH) ? 0 : col;
            above = center_row[c];
            above2 = prior_row[c];
            prior_row[c] = above;
            center_row[c] = x;
            up = up_hold;
            down = down_hold;
            window[0] = window[1];
            window[1] = window[2];
            window[2] = above;
            up_hold = above2;
            down_hold = x;
            col++;
            if (col >= frame_w)
            begin
                col = 0;
                row++;
            end
            if (!may_emit) return;
            qr = emitted / frame_w;
            qc = emitted % frame_w;
            r.pixel = window[1];
            r.clipped = 1'b0;
            r.last = (emitted + 1 == frame_w * frame_h);
            if (qr != 0 && qr != frame_h - 1 && qc != 0 && qc != frame_w - 1)
            begin
                lap = longint'(up) + longint'(down) + longint'(window[0])
                    + longint'(window[2]) - 4 * longint'(window[1]);
                acc = (longint'(window[1]) <<< GAIN_SHIFT) + longint'(gain) * lap;
                acc = acc >>> GAIN_SHIFT;
                if (acc < 0)
                begin
                    r.pixel = '0;
                    r.clipped = 1'b1;
                end
                else if (acc > 65535)
                begin
                    r.pixel = '1;
                    r.clipped = 1'b1;
                end
                else
                begin
                    r.pixel = acc[PIX_W-1:0];
                end
            end
            pending_results.push_back(r);
            emitted++;
        endfunction

        function void note_beat(item_kind_t kind, pixel_t pix, logic sof);
            if (kind == ITEM_PIXEL)
            begin
                if (sof || (row == 0 && col == 0 && emitted == 0))
                begin
                    frame_w = clamp_dim(width_reg, TB_MAX_WIDTH);
                    frame_h = clamp_dim(height_reg, MAX_HEIGHT);
                    col = 0;
                    row = 0;
                    emitted = 0;
                end
                if (row < frame_h)
                begin
                    shift_stencil(pix, row * frame_w + col >= frame_w + 1);
                    return;
                end
            end
            if (row >= frame_h && emitted < frame_w * frame_h) shift_stencil('0, 1'b1);
        endfunction

        function void check_beat(pixel_t pix, logic lst, logic clp);
            result_t want;
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: unexpected result pixel=%h last=%b clipped=%b",
                             $realtime, pix, lst, clp);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (pix !== want.pixel || lst !== want.last || clp !== want.clipped)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display({"%0t: result mismatch: expected pixel=%h last=%b clipped=%b,",
                              " got pixel=%h last=%b clipped=%b"},
                             $realtime, want.pixel, want.last, want.clipped,
                             pix, lst, clp);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = REG_GAIN;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic               cmd = ITEM_PIXEL;
    pixel_t             pixel_in = '0;
    logic               start_of_frame = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    pixel_t             pixel_out;
    logic               last;
    logic               clipped;

    diffusion_scoreboard sb = new();
    int unsigned         quiet_cycles = 0;
    int unsigned         sent_beats = 0;
    bit                  push_calm = 1'b0;
    bit                  pop_calm = 1'b0;
    int                  pop_hold = 0;

    isotropic_diffusion_stencil_core #(
        .MAX_WIDTH(TB_MAX_WIDTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .cmd(cmd),
        .pixel_in(pixel_in),
        .start_of_frame(start_of_frame),
        .empty(empty),
        .pop(pop),
        .pixel_out(pixel_out),
        .last(last),
        .clipped(clipped)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            if (!pop_calm && $urandom_range(0, 7) == 0)
                pop_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
        end
        if ($urandom_range(0, 249) == 0) pop_calm = !pop_calm;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) sb.check_beat(pixel_out, last, clipped);
            if (push && !full) sb.note_beat(item_kind_t'(cmd), pixel_in, start_of_frame);
            if ((pop && !empty) || (push && !full)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic int next_gap();
        int r;
        if (push_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic pixel_t pick_pixel(int unsigned style, int unsigned base);
        int v;
        case (style)
            0: return pixel_t'($urandom);
            1:
            begin
                v = int'(base) + $urandom_range(0, 128) - 64;
                return (v < 0) ? 16'h0000 : ((v > 65535) ? 16'hFFFF : pixel_t'(v));
            end
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return $urandom_range(0, 1) ? pixel_t'($urandom_range(0, 255))
                                                 : pixel_t'(65535 - $urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_beat(item_kind_t kind, pixel_t pix, logic sof, int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        cmd <= kind;
        pixel_in <= pix;
        start_of_frame <= sof;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        sent_beats++;
    endtask

    task automatic drain_and_pause();
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(int unsigned gain, int unsigned raw_w, int unsigned raw_h);
        cfg_we <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_data <= CFG_W'(gain);
        @(negedge clk);
        cfg_index <= REG_WIDTH;
        cfg_data <= CFG_W'(raw_w);
        @(negedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= CFG_W'(raw_h);
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(REG_GAIN, gain);
        sb.set_register(REG_WIDTH, raw_w);
        sb.set_register(REG_HEIGHT, raw_h);
    endtask

    // A frame cut short never emits its remaining results; the next start of frame restarts the frame.
    task automatic stream_frame(int unsigned fw, int unsigned fh, int unsigned cut, bit noisy);
        int unsigned style;
        int unsigned base;
        int unsigned n;
        item_kind_t  kind;
        style = $urandom_range(0, 3);
        base = $urandom_range(0, 65535);
        for (n = 0; n < cut; n++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                push_beat(ITEM_DRAIN, pixel_t'($urandom), $urandom_range(0, 1), next_gap());
            push_beat(ITEM_PIXEL, pick_pixel(style, base), n == 0, next_gap());
        end
        if (cut < fw * fh) return;
        for (n = 0; n <= fw; n++)
        begin
            kind = (noisy && $urandom_range(0, 3) == 0) ? ITEM_PIXEL : ITEM_DRAIN;
            push_beat(kind, pixel_t'($urandom),
                      (kind == ITEM_DRAIN && noisy) ? $urandom_range(0, 1) : 1'b0, next_gap());
        end
        if (noisy)
        begin
            repeat ($urandom_range(0, 2))
                push_beat(ITEM_DRAIN, pixel_t'($urandom), $urandom_range(0, 1), next_gap());
            if ($urandom_range(0, 1))
                push_beat(ITEM_PIXEL, pixel_t'($urandom), 1'b0, next_gap());
        end
    endtask

    initial
    begin : stimulus
        pixel_t      cross_frame [12];
        int unsigned phase;
        int unsigned gain;
        int unsigned raw_w;
        int unsigned raw_h;
        int unsigned fw;
        int unsigned fh;
        int unsigned pick;
        int          k;
        cross_frame = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                        16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A 4x3 frame whose two interior pixels saturate high and low at full gain.
        configure(16'hFFFF, 4, 3);
        push_beat(ITEM_DRAIN, 16'h1234, 1'b1, 0);
        for (k = 0; k < 12; k++)
        begin
            push_beat(ITEM_PIXEL, cross_frame[k], 1'b0, next_gap());
            if (k == 5) push_beat(ITEM_DRAIN, 16'h5A5A, 1'b0, 0);
        end
        push_beat(ITEM_PIXEL, 16'hBEEF, 1'b0, 0);
        push_beat(ITEM_DRAIN, 16'h0000, 1'b0, 0);
        push_beat(ITEM_DRAIN, 16'h0000, 1'b1, 0);
        push_beat(ITEM_DRAIN, 16'h0000, 1'b0, 0);
        push_beat(ITEM_DRAIN, 16'h0000, 1'b0, 0);
        push_beat(ITEM_DRAIN, 16'h0000, 1'b0, 1);
        push_beat(ITEM_PIXEL, 16'h8001, 1'b0, 0);
        drain_and_pause();

        // Widest frame, only partly streamed so the run stays short.
        configure($urandom_range(0, 65535), $urandom_range(0, 1) ? 1024 : 2047,
                  $urandom_range(0, 1) ? 4096 : 8191);
        stream_frame(TB_MAX_WIDTH, MAX_HEIGHT, $urandom_range(100, 300), 1'b0);
        drain_and_pause();

        phase = 0;
        while (sent_beats < TOTAL_BEATS)
        begin
            if (phase == 0) gain = 0;
            else if (phase == 1) gain = 65535;
            else if ($urandom_range(0, 3) == 0) gain = $urandom_range(0, 1) ? 65535 : 0;
            else gain = $urandom_range(0, 65535);
            if (phase == 0) raw_w = $urandom_range(0, 2);
            else if ($urandom_range(0, 5) == 0) raw_w = $urandom_range(9, 20);
            else raw_w = $urandom_range(3, 8);
            raw_h = (phase == 1) ? $urandom_range(0, 2) : $urandom_range(3, 5);
            configure(gain, raw_w, raw_h);
            fw = clamp_dim(raw_w, TB_MAX_WIDTH);
            fh = clamp_dim(raw_h, MAX_HEIGHT);
            repeat ($urandom_range(2, 4))
            begin
                push_calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    stream_frame(fw, fh, fw * fh, $urandom_range(0, 2) == 0);
                else if (pick < 8)
                    stream_frame(fw, fh, $urandom_range(1, fw * fh - 1), $urandom_range(0, 1));
                else
                    repeat ($urandom_range(1, 6))
                        push_beat(item_kind_t'($urandom_range(0, 1)), pixel_t'($urandom),
                                  $urandom_range(0, 3) == 0, next_gap());
            end
            drain_and_pause();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
